// ===== hdl/ctp_pkg.sv =====
// Shared types, character codes and widths for the command line token parser.
package ctp_pkg;

    // Default limit on parameters per command.
    localparam int MAX_PARAMS_DEF = 32;

    // Field widths of a result.
    localparam int LETTER_W = 2;
    localparam int CODE_W   = 16;
    localparam int PIDX_W   = 5;
    localparam int MANT_W   = 32;
    localparam int FRAC_W   = 4;

    // Stream widths.
    localparam int CHAR_W   = 8;
    localparam int FIELDS_W = LETTER_W + CODE_W + PIDX_W + MANT_W + FRAC_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int TUSER_W  = 2;

    // Command letter codes.
    localparam logic [LETTER_W-1:0] LTR_M = 2'd0;
    localparam logic [LETTER_W-1:0] LTR_R = 2'd1;
    localparam logic [LETTER_W-1:0] LTR_C = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_M = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_LOW_R = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LOW_C = 8'h63;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    // Saturation limits.
    localparam logic [CODE_W-1:0] CODE_MAX    = 16'hFFFF;
    localparam logic [MANT_W-1:0] MANT_POSLIM = 32'h7FFF_FFFF;
    localparam logic [MANT_W-1:0] MANT_NEGLIM = 32'h8000_0000;
    localparam logic [FRAC_W-1:0] FRAC_MAX    = 4'd9;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_PRECODE,
        PH_CODE,
        PH_GAP,
        PH_PARAM
    } phase_t;

    // One result as it travels to the output register.
    typedef struct packed {
        logic [LETTER_W-1:0]      cmd_letter;
        logic [CODE_W-1:0]        cmd_code;
        logic [PIDX_W-1:0]        param_index;
        logic signed [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0]        frac_digits;
        logic                     last_param;
        logic                     overflow;
        logic                     format_error;
    } result_t;

endpackage

// ===== hdl/command_line_token_parser.sv =====
// Top level of the command line token parser: input register, parser, result register.
//
//   Channel  Dir  Payload                                          Marker
//   s_*      in   tdata: char_byte                                 -
//   m_*      out  tdata: letter, code, index, mantissa, fraction   tlast = last_param
//                 tuser: overflow, format_error
//
// One character request is taken every cycle while s_tready is high; the parser state and
// the result register both update from the input register when the result register is free.
// Reset is asynchronous and active low and returns the parser to waiting for a letter.
// A stall on m_tready holds the result register and one character in the input
// register; s_tready drops only when both are full.
module command_line_token_parser
#(
    parameter int MAX_PARAMS = ctp_pkg::MAX_PARAMS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ctp_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ctp_pkg::TDATA_W-1:0] m_tdata,   // cmd_letter, cmd_code, param_index,
                                                   // mantissa, frac_digits, zero pad
    output logic                        m_tlast,   // last_param
    output logic [ctp_pkg::TUSER_W-1:0] m_tuser    // [0] overflow, [1] format_error
);

    localparam int PAD_W = ctp_pkg::TDATA_W - ctp_pkg::FIELDS_W;

    logic                       held_valid;
    logic [ctp_pkg::CHAR_W-1:0] held_char;
    logic                       step;
    logic                       res_valid;
    ctp_pkg::result_t           res;
    ctp_pkg::result_t           out_res;

    // The held character is parsed when the result register can take its outcome.
    assign step = held_valid && (!m_tvalid || m_tready);

    ctp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .take       (step),
        .held_valid (held_valid),
        .held_char  (held_char)
    );

    ctp_parser #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_byte  (held_char),
        .res_valid  (res_valid),
        .res        (res)
    );

    ctp_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .res_valid  (res_valid),
        .res        (res),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_res    (out_res)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_tdata = {{PAD_W{1'b0}},
                      out_res.frac_digits,
                      out_res.mantissa,
                      out_res.param_index,
                      out_res.cmd_code,
                      out_res.cmd_letter};
    assign m_tlast = out_res.last_param;
    assign m_tuser = {out_res.format_error, out_res.overflow};

endmodule

// ===== hdl/ctp_in_stage.sv =====
// Input register holding one character request until the parser takes it.
module ctp_in_stage
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ctp_pkg::CHAR_W-1:0] in_char,
    input  logic                       take,
    output logic                       held_valid,
    output logic [ctp_pkg::CHAR_W-1:0] held_char
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ctp_pkg::CHAR_W-1:0] char_reg;

    // The stage is free when empty or when its character moves on this cycle.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Character payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
        end
    end

    assign held_valid = valid_reg;
    assign held_char  = char_reg;

endmodule

// ===== hdl/ctp_parser.sv =====
// Parser state and the per-character next-state and result logic.
module ctp_parser
#(
    parameter int MAX_PARAMS = ctp_pkg::MAX_PARAMS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [ctp_pkg::CHAR_W-1:0] char_byte,
    output logic                       res_valid,
    output ctp_pkg::result_t           res
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PARAMS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PARAMS - 1);

    ctp_pkg::phase_t                   phase_reg, phase_next;
    logic [ctp_pkg::LETTER_W-1:0]      letter_reg, letter_next;
    logic [ctp_pkg::CODE_W-1:0]        code_reg, code_next;
    logic                              code_sat_reg, code_sat_next;
    logic [ctp_pkg::MANT_W-1:0]        mant_reg, mant_next;
    logic [ctp_pkg::FRAC_W-1:0]        frac_reg, frac_next;
    logic                              neg_reg, neg_next;
    logic                              point_reg, point_next;
    logic                              mant_sat_reg, mant_sat_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              error_reg, error_next;

    // Character classes.
    logic                              is_tilde, is_space, is_minus, is_dot, is_dig;
    logic                              is_m, is_r, is_c;
    logic [ctp_pkg::CHAR_W-1:0]        low_char;
    logic [3:0]                        dig;

    // Accumulate arithmetic.
    logic [ctp_pkg::CODE_W+3:0]        code_prod;
    logic [ctp_pkg::MANT_W+3:0]        mant_prod;
    logic [ctp_pkg::MANT_W-1:0]        mant_limit;
    logic                              mant_over;

    // Emission helpers.
    logic                              many;
    logic [CNT_W-1:0]                  idx;
    logic                              emit, emit_last, emit_zero, fail_hit;

    assign low_char = char_byte | ctp_pkg::CASE_BIT;
    assign is_tilde = (char_byte == ctp_pkg::CH_TILDE);
    assign is_space = (char_byte == ctp_pkg::CH_SPACE);
    assign is_minus = (char_byte == ctp_pkg::CH_MINUS);
    assign is_dot   = (char_byte == ctp_pkg::CH_DOT);
    assign is_dig   = (char_byte >= ctp_pkg::CH_ZERO) && (char_byte <= ctp_pkg::CH_NINE);
    assign is_m     = (low_char == ctp_pkg::CH_LOW_M);
    assign is_r     = (low_char == ctp_pkg::CH_LOW_R);
    assign is_c     = (low_char == ctp_pkg::CH_LOW_C);
    assign dig      = char_byte[3:0];

    // Times ten plus digit, as shifts and adds.
    assign code_prod = {1'b0, code_reg, 3'b0} + {3'b0, code_reg, 1'b0}
                     + {{(ctp_pkg::CODE_W){1'b0}}, dig};
    assign mant_prod = {1'b0, mant_reg, 3'b0} + {3'b0, mant_reg, 1'b0}
                     + {{(ctp_pkg::MANT_W){1'b0}}, dig};
    assign mant_limit = neg_reg ? ctp_pkg::MANT_NEGLIM : ctp_pkg::MANT_POSLIM;
    assign mant_over  = (mant_prod > {4'b0, mant_limit});

    // Index clamps at the last slot once the limit is reached.
    assign many = (count_reg >= CNT_MAX);
    assign idx  = many ? CNT_LAST : count_reg;

    // Next state and result for the held character.
    always_comb
    begin
        phase_next    = phase_reg;
        letter_next   = letter_reg;
        code_next     = code_reg;
        code_sat_next = code_sat_reg;
        mant_next     = mant_reg;
        frac_next     = frac_reg;
        neg_next      = neg_reg;
        point_next    = point_reg;
        mant_sat_next = mant_sat_reg;
        count_next    = count_reg;
        error_next    = error_reg;
        res_valid     = 1'b0;
        res           = '0;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_zero     = 1'b0;
        fail_hit      = 1'b0;

        if (step)
        begin
            if (error_reg)
            begin
                // Skipping to the terminator after a malformed command.
                if (is_tilde)
                begin
                    res_valid        = 1'b1;
                    res.last_param   = 1'b1;
                    res.format_error = 1'b1;
                    error_next       = 1'b0;
                    phase_next       = ctp_pkg::PH_WAIT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    ctp_pkg::PH_WAIT:
                    begin
                        if (!is_space && !is_tilde)
                        begin
                            if (is_m || is_r || is_c)
                            begin
                                letter_next   = is_m ? ctp_pkg::LTR_M :
                                                (is_r ? ctp_pkg::LTR_R : ctp_pkg::LTR_C);
                                code_next     = '0;
                                code_sat_next = 1'b0;
                                count_next    = '0;
                                mant_next     = '0;
                                frac_next     = '0;
                                neg_next      = 1'b0;
                                point_next    = 1'b0;
                                mant_sat_next = 1'b0;
                                phase_next    = ctp_pkg::PH_PRECODE;
                            end
                            else
                            begin
                                fail_hit = 1'b1;
                            end
                        end
                    end
                    ctp_pkg::PH_PRECODE:
                    begin
                        if (!is_space)
                        begin
                            if (is_dig)
                            begin
                                code_next  = ctp_pkg::CODE_W'(dig);
                                phase_next = ctp_pkg::PH_CODE;
                            end
                            else
                            begin
                                fail_hit = 1'b1;
                            end
                        end
                    end
                    ctp_pkg::PH_CODE:
                    begin
                        if (is_dig)
                        begin
                            if (code_prod > {4'b0, ctp_pkg::CODE_MAX})
                            begin
                                code_next     = ctp_pkg::CODE_MAX;
                                code_sat_next = 1'b1;
                            end
                            else
                            begin
                                code_next = code_prod[ctp_pkg::CODE_W-1:0];
                            end
                        end
                        else if (is_space)
                        begin
                            phase_next = ctp_pkg::PH_GAP;
                        end
                        else if (is_tilde)
                        begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            phase_next = ctp_pkg::PH_WAIT;
                        end
                        else if (is_minus || is_dot)
                        begin
                            mant_next     = '0;
                            frac_next     = '0;
                            neg_next      = is_minus;
                            point_next    = is_dot;
                            mant_sat_next = 1'b0;
                            phase_next    = ctp_pkg::PH_PARAM;
                        end
                        else
                        begin
                            fail_hit = 1'b1;
                        end
                    end
                    ctp_pkg::PH_GAP:
                    begin
                        if (is_tilde)
                        begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            emit_zero  = 1'b1;
                            phase_next = ctp_pkg::PH_WAIT;
                        end
                        else if (is_minus || is_dot || is_dig)
                        begin
                            // A first digit lands in an empty accumulator.
                            mant_next     = is_dig ? ctp_pkg::MANT_W'(dig) : '0;
                            frac_next     = '0;
                            neg_next      = is_minus;
                            point_next    = is_dot;
                            mant_sat_next = 1'b0;
                            phase_next    = ctp_pkg::PH_PARAM;
                        end
                        else if (!is_space)
                        begin
                            fail_hit = 1'b1;
                        end
                    end
                    ctp_pkg::PH_PARAM:
                    begin
                        if (is_dig)
                        begin
                            // Digits after saturation or past nine decimals are dropped.
                            if (!mant_sat_reg && !(point_reg && frac_reg >= ctp_pkg::FRAC_MAX))
                            begin
                                if (mant_over)
                                begin
                                    mant_next     = mant_limit;
                                    mant_sat_next = 1'b1;
                                end
                                else
                                begin
                                    mant_next = mant_prod[ctp_pkg::MANT_W-1:0];
                                    if (point_reg)
                                    begin
                                        frac_next = frac_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        else if (is_dot && !point_reg)
                        begin
                            point_next = 1'b1;
                        end
                        else if (is_space)
                        begin
                            emit       = 1'b1;
                            phase_next = ctp_pkg::PH_GAP;
                        end
                        else if (is_tilde)
                        begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            phase_next = ctp_pkg::PH_WAIT;
                        end
                        else
                        begin
                            fail_hit = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = ctp_pkg::PH_WAIT;
                    end
                endcase

                // Completed parameter: build the result and clear the accumulator.
                if (emit)
                begin
                    res_valid       = 1'b1;
                    res.cmd_letter  = letter_reg;
                    res.cmd_code    = code_reg;
                    res.param_index = ctp_pkg::PIDX_W'(idx);
                    res.mantissa    = emit_zero ? '0 :
                                      (neg_reg ? -mant_reg : mant_reg);
                    res.frac_digits = emit_zero ? '0 : frac_reg;
                    res.last_param  = emit_last;
                    res.overflow    = code_sat_reg || (mant_sat_reg && !emit_zero) || many;
                    count_next      = many ? count_reg : count_reg + 1'b1;
                    mant_next       = '0;
                    frac_next       = '0;
                    neg_next        = 1'b0;
                    point_next      = 1'b0;
                    mant_sat_next   = 1'b0;
                end

                // Malformed input: report now on a terminator, else skip to one.
                if (fail_hit)
                begin
                    if (is_tilde)
                    begin
                        res_valid        = 1'b1;
                        res.last_param   = 1'b1;
                        res.format_error = 1'b1;
                        phase_next       = ctp_pkg::PH_WAIT;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ctp_pkg::PH_WAIT;
            letter_reg   <= '0;
            code_reg     <= '0;
            code_sat_reg <= 1'b0;
            mant_reg     <= '0;
            frac_reg     <= '0;
            neg_reg      <= 1'b0;
            point_reg    <= 1'b0;
            mant_sat_reg <= 1'b0;
            count_reg    <= '0;
            error_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            letter_reg   <= letter_next;
            code_reg     <= code_next;
            code_sat_reg <= code_sat_next;
            mant_reg     <= mant_next;
            frac_reg     <= frac_next;
            neg_reg      <= neg_next;
            point_reg    <= point_next;
            mant_sat_reg <= mant_sat_next;
            count_reg    <= count_next;
            error_reg    <= error_next;
        end
    end

endmodule

// ===== hdl/ctp_out_stage.sv =====
// Result register that holds one result until the downstream side takes it.
module ctp_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  ctp_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output ctp_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    ctp_pkg::result_t res_reg;

    // A load happens only when the register is empty or being drained.
    always_comb
    begin
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== tb/sv/command_line_token_parser_test.sv =====
// Testbench for the command line token parser: directed and random command text checked
// against a behavioral parser kept in step with every accepted character.
module command_line_token_parser_test;

    localparam int PARAM_LIMIT = ctp_pkg::MAX_PARAMS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_CHARS = 410;
    localparam int HOLD_CYCLES = 200;

    // Bit offsets of the result fields inside m_tdata, lowest field first.
    localparam int OFS_CODE = ctp_pkg::LETTER_W;
    localparam int OFS_PIDX = OFS_CODE + ctp_pkg::CODE_W;
    localparam int OFS_MANT = OFS_PIDX + ctp_pkg::PIDX_W;
    localparam int OFS_FRAC = OFS_MANT + ctp_pkg::MANT_W;

    // One row of the directed stimulus; typed rows carry their result written out.
    typedef struct packed {
        logic [ctp_pkg::CHAR_W-1:0] ch;
        logic                       typed;
        ctp_pkg::result_t           res;
    } stim_row_t;

    localparam ctp_pkg::result_t NO_RES  = '0;
    localparam ctp_pkg::result_t M0_LAST =
        '{ctp_pkg::LTR_M, 16'd0, 5'd0, 32'sd0, 4'd0, 1'b1, 1'b0, 1'b0};
    localparam ctp_pkg::result_t BAD_CMD =
        '{ctp_pkg::LTR_M, 16'd0, 5'd0, 32'sd0, 4'd0, 1'b1, 1'b0, 1'b1};

    // Ignored terminator, shortest command, bad letter, missing code, saturated code
    // with a negative fraction and a trailing space, and a stray byte in a command.
    localparam stim_row_t DIRECTED [25] = '{
        '{ctp_pkg::CH_TILDE, 1'b0, NO_RES},
        '{"m",               1'b0, NO_RES},
        '{"0",               1'b0, NO_RES},
        '{ctp_pkg::CH_TILDE, 1'b1, M0_LAST},
        '{"Q",               1'b0, NO_RES},
        '{ctp_pkg::CH_TILDE, 1'b1, BAD_CMD},
        '{"R",               1'b0, NO_RES},
        '{ctp_pkg::CH_TILDE, 1'b1, BAD_CMD},
        '{ctp_pkg::CH_SPACE, 1'b0, NO_RES},
        '{"c",               1'b0, NO_RES},
        '{"7",               1'b0, NO_RES},
        '{"0",               1'b0, NO_RES},
        '{"0",               1'b0, NO_RES},
        '{"0",               1'b0, NO_RES},
        '{"0",               1'b0, NO_RES},
        '{ctp_pkg::CH_MINUS, 1'b0, NO_RES},
        '{"9",               1'b0, NO_RES},
        '{ctp_pkg::CH_DOT,   1'b0, NO_RES},
        '{"5",               1'b0, NO_RES},
        '{ctp_pkg::CH_SPACE, 1'b0, NO_RES},
        '{ctp_pkg::CH_TILDE, 1'b0, NO_RES},
        '{"M",               1'b0, NO_RES},
        '{"1",               1'b0, NO_RES},
        '{"a",               1'b0, NO_RES},
        '{ctp_pkg::CH_TILDE, 1'b1, BAD_CMD}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [ctp_pkg::CHAR_W-1:0]   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [ctp_pkg::TDATA_W-1:0]  m_tdata;
    logic                         m_tlast;
    logic [ctp_pkg::TUSER_W-1:0]  m_tuser;

    int send_idle = 0;
    int recv_idle = 0;
    bit squeeze_go = 1'b0;
    bit hold_rx = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    ctp_pkg::result_t pending_results[$];
    logic [ctp_pkg::CHAR_W-1:0] command_text[$];

    // Parser state mirrored by the testbench.
    ctp_pkg::phase_t parse_phase = ctp_pkg::PH_WAIT;
    logic [1:0]      cur_letter = '0;
    logic [31:0]     cur_code = '0;
    logic            code_sat = 1'b0;
    logic [31:0]     acc_mag = '0;
    logic [3:0]      acc_frac = '0;
    logic            acc_neg = 1'b0;
    logic            acc_point = 1'b0;
    logic            acc_sat = 1'b0;
    int              param_cnt = 0;
    logic            skip_mode = 1'b0;

    command_line_token_parser uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock with a period of two time units.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_digit(input logic [ctp_pkg::CHAR_W-1:0] ch);
        return ch >= ctp_pkg::CH_ZERO && ch <= ctp_pkg::CH_NINE;
    endfunction

    function automatic void param_clear();
        acc_mag = '0;
        acc_frac = '0;
        acc_neg = 1'b0;
        acc_point = 1'b0;
        acc_sat = 1'b0;
    endfunction

    // A malformed command ends with a result that carries only the error and last flags.
    function automatic ctp_pkg::result_t error_result();
        ctp_pkg::result_t r;
        r = '0;
        r.last_param = 1'b1;
        r.format_error = 1'b1;
        skip_mode = 1'b0;
        parse_phase = ctp_pkg::PH_WAIT;
        return r;
    endfunction

    function automatic bit reject(input logic [ctp_pkg::CHAR_W-1:0] ch,
                                  output ctp_pkg::result_t r);
        r = '0;
        if (ch == ctp_pkg::CH_TILDE)
        begin
            r = error_result();
            return 1'b1;
        end
        skip_mode = 1'b1;
        return 1'b0;
    endfunction

    // Completed parameter; the index sticks at the top once the limit is passed.
    function automatic ctp_pkg::result_t param_result(input bit fin);
        ctp_pkg::result_t r;
        bit many;
        int idx;
        many = param_cnt >= PARAM_LIMIT;
        idx = many ? PARAM_LIMIT - 1 : param_cnt;
        r.cmd_letter = cur_letter;
        r.cmd_code = cur_code[ctp_pkg::CODE_W-1:0];
        r.param_index = idx[ctp_pkg::PIDX_W-1:0];
        r.mantissa = acc_neg ? (32'd0 - acc_mag) : acc_mag;
        r.frac_digits = acc_frac;
        r.last_param = fin;
        r.overflow = code_sat || acc_sat || many;
        r.format_error = 1'b0;
        if (!many)
            param_cnt++;
        param_clear();
        return r;
    endfunction

    // Accumulate one digit, clamping the magnitude and dropping a tenth fraction digit.
    function automatic void add_digit(input logic [31:0] d);
        logic [31:0] limit;
        limit = acc_neg ? ctp_pkg::MANT_NEGLIM : ctp_pkg::MANT_POSLIM;
        if (acc_sat)
            return;
        if (acc_point && acc_frac >= ctp_pkg::FRAC_MAX)
            return;
        if (acc_mag > (limit - d) / 32'd10)
        begin
            acc_mag = limit;
            acc_sat = 1'b1;
            return;
        end
        acc_mag = acc_mag * 32'd10 + d;
        if (acc_point)
            acc_frac++;
    endfunction

    function automatic bit begin_param(input logic [ctp_pkg::CHAR_W-1:0] ch);
        param_clear();
        if (ch == ctp_pkg::CH_MINUS)
            acc_neg = 1'b1;
        else if (ch == ctp_pkg::CH_DOT)
            acc_point = 1'b1;
        else if (is_digit(ch))
            add_digit(32'(ch - ctp_pkg::CH_ZERO));
        else
            return 1'b0;
        parse_phase = ctp_pkg::PH_PARAM;
        return 1'b1;
    endfunction

    // Advance the mirrored parser by one character; returns 1 when a result is due.
    function automatic bit parse_char(input logic [ctp_pkg::CHAR_W-1:0] ch,
                                      output ctp_pkg::result_t r);
        logic [ctp_pkg::CHAR_W-1:0] lowc;
        lowc = ch | ctp_pkg::CASE_BIT;
        r = '0;
        if (skip_mode)
        begin
            if (ch == ctp_pkg::CH_TILDE)
            begin
                r = error_result();
                return 1'b1;
            end
            return 1'b0;
        end
        case (parse_phase)
            ctp_pkg::PH_WAIT:
            begin
                if (ch == ctp_pkg::CH_SPACE || ch == ctp_pkg::CH_TILDE)
                    return 1'b0;
                if (lowc == ctp_pkg::CH_LOW_M)
                    cur_letter = ctp_pkg::LTR_M;
                else if (lowc == ctp_pkg::CH_LOW_R)
                    cur_letter = ctp_pkg::LTR_R;
                else if (lowc == ctp_pkg::CH_LOW_C)
                    cur_letter = ctp_pkg::LTR_C;
                else
                    return reject(ch, r);
                cur_code = '0;
                code_sat = 1'b0;
                param_cnt = 0;
                param_clear();
                parse_phase = ctp_pkg::PH_PRECODE;
                return 1'b0;
            end
            ctp_pkg::PH_PRECODE:
            begin
                if (ch == ctp_pkg::CH_SPACE)
                    return 1'b0;
                if (!is_digit(ch))
                    return reject(ch, r);
                cur_code = 32'(ch - ctp_pkg::CH_ZERO);
                parse_phase = ctp_pkg::PH_CODE;
                return 1'b0;
            end
            ctp_pkg::PH_CODE:
            begin
                if (is_digit(ch))
                begin
                    cur_code = cur_code * 32'd10 + 32'(ch - ctp_pkg::CH_ZERO);
                    if (cur_code > 32'(ctp_pkg::CODE_MAX))
                    begin
                        cur_code = 32'(ctp_pkg::CODE_MAX);
                        code_sat = 1'b1;
                    end
                    return 1'b0;
                end
                if (ch == ctp_pkg::CH_SPACE)
                begin
                    parse_phase = ctp_pkg::PH_GAP;
                    return 1'b0;
                end
                if (ch == ctp_pkg::CH_TILDE)
                begin
                    parse_phase = ctp_pkg::PH_WAIT;
                    r = param_result(1'b1);
                    return 1'b1;
                end
                if (ch == ctp_pkg::CH_MINUS || ch == ctp_pkg::CH_DOT)
                begin
                    void'(begin_param(ch));
                    return 1'b0;
                end
                return reject(ch, r);
            end
            ctp_pkg::PH_GAP:
            begin
                if (ch == ctp_pkg::CH_SPACE)
                    return 1'b0;
                if (ch == ctp_pkg::CH_TILDE)
                begin
                    param_clear();
                    parse_phase = ctp_pkg::PH_WAIT;
                    r = param_result(1'b1);
                    return 1'b1;
                end
                if (begin_param(ch))
                    return 1'b0;
                return reject(ch, r);
            end
            ctp_pkg::PH_PARAM:
            begin
                if (is_digit(ch))
                begin
                    add_digit(32'(ch - ctp_pkg::CH_ZERO));
                    return 1'b0;
                end
                if (ch == ctp_pkg::CH_DOT && !acc_point)
                begin
                    acc_point = 1'b1;
                    return 1'b0;
                end
                if (ch == ctp_pkg::CH_SPACE)
                begin
                    parse_phase = ctp_pkg::PH_GAP;
                    r = param_result(1'b0);
                    return 1'b1;
                end
                if (ch == ctp_pkg::CH_TILDE)
                begin
                    parse_phase = ctp_pkg::PH_WAIT;
                    r = param_result(1'b1);
                    return 1'b1;
                end
                return reject(ch, r);
            end
            default:
            begin
                parse_phase = ctp_pkg::PH_WAIT;
                return 1'b0;
            end
        endcase
    endfunction

    // Append a character, now and then preceded by a random noise byte.
    function automatic void add_text(input logic [ctp_pkg::CHAR_W-1:0] c);
        if ($urandom_range(99) < 3)
            command_text.push_back(8'($urandom_range(255)));
        command_text.push_back(c);
    endfunction

    // Build one mostly well formed command with random content.
    function automatic void make_command();
        string letters;
        string big;
        int n_params;
        int n_digits;
        int point_at;
        int pick;
        bit neg;
        letters = "MRCmrc";
        repeat ($urandom_range(2))
            add_text(ctp_pkg::CH_SPACE);
        if ($urandom_range(99) < 6)
            add_text(8'($urandom_range(255)));
        else
            add_text(letters[$urandom_range(5)]);
        if ($urandom_range(99) < 10)
            add_text(ctp_pkg::CH_SPACE);

        // Code: sometimes missing, sometimes long enough to saturate.
        pick = $urandom_range(99);
        n_digits = (pick < 5) ? 0 : (pick < 13) ? $urandom_range(7, 5) : $urandom_range(3, 1);
        repeat (n_digits)
            add_text(ctp_pkg::CH_ZERO + 8'($urandom_range(9)));

        n_params = ($urandom_range(99) < 3) ? $urandom_range(35, 31) : $urandom_range(4);
        for (int p = 0; p < n_params; p++)
        begin
            if (p > 0 || $urandom_range(99) >= 10)
                repeat ($urandom_range(2, 1))
                    add_text(ctp_pkg::CH_SPACE);
            neg = $urandom_range(99) < 30;
            if (neg)
                add_text(ctp_pkg::CH_MINUS);
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // Values at the edge of the signed range.
                case ($urandom_range(2))
                    0: big = "2147483647";
                    1: big = "2147483648";
                    default: big = "2147483649";
                endcase
                for (int k = 0; k < big.len(); k++)
                    add_text(big[k]);
            end
            else
            begin
                n_digits = (pick < 14) ? $urandom_range(12, 9) : $urandom_range(4);
                point_at = ($urandom_range(99) < 40) ? $urandom_range(n_digits) : -1;
                if (n_digits == 0 && !neg)
                    point_at = 0;
                for (int k = 0; k <= n_digits; k++)
                begin
                    if (k == point_at)
                        add_text(ctp_pkg::CH_DOT);
                    if (k < n_digits)
                        add_text(ctp_pkg::CH_ZERO + 8'($urandom_range(9)));
                end
                // A second point is a stray byte.
                if (point_at >= 0 && $urandom_range(99) < 4)
                    add_text(ctp_pkg::CH_DOT);
            end
        end
        if ($urandom_range(99) < 20)
            add_text(ctp_pkg::CH_SPACE);
        add_text(ctp_pkg::CH_TILDE);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        if (mismatch_count < 40)
            $display("cycle %0d: %s got %0h, expected %0h", cycle_count, what, got_v, want_v);
        mismatch_count++;
    endtask

    // Offer one character request; called and returning at a falling edge.
    task automatic send_char(input logic [ctp_pkg::CHAR_W-1:0] ch, input logic typed,
                             input ctp_pkg::result_t typed_res);
        ctp_pkg::result_t r;
        bit has_res;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        has_res = parse_char(ch, r);
        if (typed)
            pending_results.push_back(typed_res);
        else if (has_res)
            pending_results.push_back(r);
        @(negedge clk);
    endtask

    // Receiver readiness, with a long hold-off on request.
    always @(negedge clk)
        m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle);

    // Long receiver stall, counted in cycles, while the sender keeps offering.
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_rx = 1'b0;
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        ctp_pkg::result_t got;
        ctp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cmd_letter = m_tdata[0 +: ctp_pkg::LETTER_W];
            got.cmd_code = m_tdata[OFS_CODE +: ctp_pkg::CODE_W];
            got.param_index = m_tdata[OFS_PIDX +: ctp_pkg::PIDX_W];
            got.mantissa = m_tdata[OFS_MANT +: ctp_pkg::MANT_W];
            got.frac_digits = m_tdata[OFS_FRAC +: ctp_pkg::FRAC_W];
            got.last_param = m_tlast;
            got.overflow = m_tuser[0];
            got.format_error = m_tuser[1];
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", 64'(got), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (got.cmd_letter !== want.cmd_letter)
                    report_mismatch("cmd_letter", 64'(got.cmd_letter),
                                    64'(want.cmd_letter));
                if (got.cmd_code !== want.cmd_code)
                    report_mismatch("cmd_code", 64'(got.cmd_code), 64'(want.cmd_code));
                if (got.param_index !== want.param_index)
                    report_mismatch("param_index", 64'(got.param_index),
                                    64'(want.param_index));
                if (got.mantissa !== want.mantissa)
                    report_mismatch("mantissa", 64'(unsigned'(got.mantissa)),
                                    64'(unsigned'(want.mantissa)));
                if (got.frac_digits !== want.frac_digits)
                    report_mismatch("frac_digits", 64'(got.frac_digits),
                                    64'(want.frac_digits));
                if (got.last_param !== want.last_param)
                    report_mismatch("last_param", 64'(got.last_param),
                                    64'(want.last_param));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
                if (got.format_error !== want.format_error)
                    report_mismatch("format_error", 64'(got.format_error),
                                    64'(want.format_error));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Reset, directed rows, then three random phases with different idling.
    initial
    begin
        int sent;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle = 33;
        recv_idle = 58;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_char(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].res);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 33 : (ph == 1) ? 58 : 0;
            recv_idle = (ph == 0) ? 58 : (ph == 1) ? 33 : 0;
            if (ph == 2)
                squeeze_go = 1'b1;
            sent = 0;
            while (sent < PHASE_CHARS)
            begin
                make_command();
                while (command_text.size() != 0)
                begin
                    send_char(command_text.pop_front(), 1'b0, NO_RES);
                    sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for the pipeline latency.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
